[src/rei_pkg.sv]
`timescale 1ns / 1ps
package rei_pkg;

   localparam int FRAC_BITS = 14;
   localparam int IO_W = 16;
   localparam int PROD_W = 2 * IO_W;

   // largest power of two bounding the rounded step term or the input part
   localparam int STEP_LOG = (PROD_W - 2 - FRAC_BITS > IO_W - 1) ?
                             (PROD_W - 2 - FRAC_BITS) : (IO_W - 1);
   localparam int MAG_W = STEP_LOG + 2;
   localparam int STEP_W = MAG_W + 1;
   localparam int SQ_W = 2 * MAG_W;
   localparam int M2_W = SQ_W + 1;

   // quotient of a^2 * 4^(F+1) by the squared length, never above 4^(F+1)
   localparam int QUO_W = 2 * FRAC_BITS + 3;
   localparam int ROOT_W = FRAC_BITS + 2;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int SQRT_REM_W = ROOT_W + 2;

   localparam int SAT_W = ((ROOT_W > IO_W) ? ROOT_W : IO_W) + 1;
   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 <<< (IO_W - 1)) - 1);
   localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

   localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) <<< (FRAC_BITS - 1);

   localparam int STEP_STAGES = 4;
   localparam int LATENCY = STEP_STAGES + QUO_W + ROOT_W + 1;

   typedef struct packed {
      logic neg;
      logic zero;
   } side_type;

endpackage

[src/rotation_euler_integrate_unit.sv]
// Euler step of a 2D rotation (c, s) by angle d, then scaled back to unit length.
// An item enters whenever start is high; busy is never raised, so one item is
// taken every cycle. Each item comes back in order as a single-cycle rsp_valid
// strobe, with cos and sin in Q2.14. Nothing holds results back: the receiver
// must take each one in the cycle it is shown.
// Each lane holds two pipelined units: a restoring divider that
// resolves one quotient bit per stage (2*FRAC_BITS+3 stages) and a square root
// that resolves one root bit per stage (FRAC_BITS+2 stages), behind four stages
// of multiply, round, square and sum, and one output register.
`timescale 1ns / 1ps
module rotation_euler_integrate_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [rei_pkg::IO_W-1:0] req_cos_in,
   input  logic signed [rei_pkg::IO_W-1:0] req_sin_in,
   input  logic signed [rei_pkg::IO_W-1:0] req_delta_angle,
   output logic                            rsp_valid,
   output logic signed [rei_pkg::IO_W-1:0] rsp_cos_out,
   output logic signed [rei_pkg::IO_W-1:0] rsp_sin_out,
   output logic                            rsp_zero_magnitude
);
   import rei_pkg::*;

   logic             req_fire;
   logic             step_valid;
   logic [M2_W-1:0]  mag_sq;
   logic [SQ_W-1:0]  num_cos, num_sin;
   side_type         step_side_cos, step_side_sin;

   logic             div_valid_cos, div_valid_sin;
   logic [QUO_W-1:0] quo_cos, quo_sin;
   side_type         div_side_cos, div_side_sin;

   logic              root_valid_cos, root_valid_sin;
   logic [ROOT_W-1:0] root_cos, root_sin;
   side_type          root_side_cos, root_side_sin;

   logic                   rsp_valid_ff;
   logic signed [IO_W-1:0] rsp_cos_ff, rsp_sin_ff;
   logic                   rsp_zero_ff;

   // q = floor((root + 1) / 2), then sign and clamp, or zero when flagged
   function automatic logic signed [IO_W-1:0] finish_part(logic [ROOT_W-1:0] r, side_type sd);
      logic [ROOT_W:0]         rnd;
      logic signed [SAT_W-1:0] mag;
      logic signed [SAT_W-1:0] val;
      logic signed [IO_W-1:0]  res;
      rnd = (ROOT_W + 1)'(r) + (ROOT_W + 1)'(1);
      mag = SAT_W'(rnd[ROOT_W:1]);
      val = sd.neg ? -mag : mag;
      if (sd.zero) begin
         res = '0;
      end else if (val > SAT_HI) begin
         res = IO_W'(SAT_HI);
      end else if (val < SAT_LO) begin
         res = IO_W'(SAT_LO);
      end else begin
         res = IO_W'(val);
      end
      return res;
   endfunction

   assign busy     = 1'b0;
   assign req_fire = start & ~busy;

   rei_step u_step (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_fire),
      .cos_in      (req_cos_in),
      .sin_in      (req_sin_in),
      .delta_angle (req_delta_angle),
      .out_valid   (step_valid),
      .mag_sq      (mag_sq),
      .num_cos     (num_cos),
      .num_sin     (num_sin),
      .side_cos    (step_side_cos),
      .side_sin    (step_side_sin)
   );

   rei_div u_div_cos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .num       (num_cos),
      .den       (mag_sq),
      .side_in   (step_side_cos),
      .out_valid (div_valid_cos),
      .quo       (quo_cos),
      .side_out  (div_side_cos)
   );

   rei_div u_div_sin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_valid),
      .num       (num_sin),
      .den       (mag_sq),
      .side_in   (step_side_sin),
      .out_valid (div_valid_sin),
      .quo       (quo_sin),
      .side_out  (div_side_sin)
   );

   rei_sqrt u_sqrt_cos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid_cos),
      .rad       (quo_cos),
      .side_in   (div_side_cos),
      .out_valid (root_valid_cos),
      .root      (root_cos),
      .side_out  (root_side_cos)
   );

   rei_sqrt u_sqrt_sin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid_sin),
      .rad       (quo_sin),
      .side_in   (div_side_sin),
      .out_valid (root_valid_sin),
      .root      (root_sin),
      .side_out  (root_side_sin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= root_valid_cos & root_valid_sin;
      end
      rsp_cos_ff  <= finish_part(root_cos, root_side_cos);
      rsp_sin_ff  <= finish_part(root_sin, root_side_sin);
      rsp_zero_ff <= root_side_cos.zero;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cos_out        = rsp_cos_ff;
   assign rsp_sin_out        = rsp_sin_ff;
   assign rsp_zero_magnitude = rsp_zero_ff;

endmodule

[src/rei_step.sv]
`timescale 1ns / 1ps
module rei_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [rei_pkg::IO_W-1:0]  cos_in,
   input  logic signed [rei_pkg::IO_W-1:0]  sin_in,
   input  logic signed [rei_pkg::IO_W-1:0]  delta_angle,
   output logic                             out_valid,
   output logic [rei_pkg::M2_W-1:0]         mag_sq,
   output logic [rei_pkg::SQ_W-1:0]         num_cos,
   output logic [rei_pkg::SQ_W-1:0]         num_sin,
   output rei_pkg::side_type                side_cos,
   output rei_pkg::side_type                side_sin
);
   import rei_pkg::*;

   // stage 1: products
   logic                     valid1_ff;
   logic signed [IO_W-1:0]   cos1_ff, sin1_ff;
   logic signed [PROD_W-1:0] prod_ds_in, prod_dc_in;
   logic signed [PROD_W-1:0] prod_ds_ff, prod_dc_ff;

   // stage 2: stepped pair
   logic signed [PROD_W:0]   rnd_ds, rnd_dc;
   logic signed [PROD_W:0]   shr_ds, shr_dc;
   logic                     valid2_ff;
   logic signed [STEP_W-1:0] cos2_in, sin2_in;
   logic signed [STEP_W-1:0] cos2_ff, sin2_ff;

   // stage 3: squares
   logic signed [2*STEP_W-1:0] sq_cos_full, sq_sin_full;
   logic                       valid3_ff;
   logic [SQ_W-1:0]            sq_cos_ff, sq_sin_ff;
   logic                       neg_cos3_ff, neg_sin3_ff;

   // stage 4: squared length
   logic [M2_W-1:0] mag_sq_in;
   logic            valid4_ff;
   logic [M2_W-1:0] mag_sq_ff;
   logic [SQ_W-1:0] num_cos_ff, num_sin_ff;
   side_type        side_cos_ff, side_sin_ff;

   assign prod_ds_in = PROD_W'(delta_angle) * PROD_W'(sin_in);
   assign prod_dc_in = PROD_W'(delta_angle) * PROD_W'(cos_in);

   // round to nearest, ties upward
   assign rnd_ds = (PROD_W + 1)'(prod_ds_ff) + ROUND_HALF;
   assign rnd_dc = (PROD_W + 1)'(prod_dc_ff) + ROUND_HALF;
   assign shr_ds = rnd_ds >>> FRAC_BITS;
   assign shr_dc = rnd_dc >>> FRAC_BITS;
   assign cos2_in = STEP_W'(cos1_ff) - STEP_W'(shr_ds);
   assign sin2_in = STEP_W'(sin1_ff) + STEP_W'(shr_dc);

   assign sq_cos_full = (2 * STEP_W)'(cos2_ff) * (2 * STEP_W)'(cos2_ff);
   assign sq_sin_full = (2 * STEP_W)'(sin2_ff) * (2 * STEP_W)'(sin2_ff);

   assign mag_sq_in = M2_W'(sq_cos_ff) + M2_W'(sq_sin_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
      cos1_ff          <= cos_in;
      sin1_ff          <= sin_in;
      prod_ds_ff       <= prod_ds_in;
      prod_dc_ff       <= prod_dc_in;
      cos2_ff          <= cos2_in;
      sin2_ff          <= sin2_in;
      sq_cos_ff        <= SQ_W'(sq_cos_full);
      sq_sin_ff        <= SQ_W'(sq_sin_full);
      neg_cos3_ff      <= cos2_ff[STEP_W-1];
      neg_sin3_ff      <= sin2_ff[STEP_W-1];
      mag_sq_ff        <= mag_sq_in;
      num_cos_ff       <= sq_cos_ff;
      num_sin_ff       <= sq_sin_ff;
      side_cos_ff.neg  <= neg_cos3_ff;
      side_cos_ff.zero <= (mag_sq_in == '0);
      side_sin_ff.neg  <= neg_sin3_ff;
      side_sin_ff.zero <= (mag_sq_in == '0);
   end

   assign out_valid = valid4_ff;
   assign mag_sq    = mag_sq_ff;
   assign num_cos   = num_cos_ff;
   assign num_sin   = num_sin_ff;
   assign side_cos  = side_cos_ff;
   assign side_sin  = side_sin_ff;

endmodule

[src/rei_div.sv]
`timescale 1ns / 1ps
module rei_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [rei_pkg::SQ_W-1:0]    num,
   input  logic [rei_pkg::M2_W-1:0]    den,
   input  rei_pkg::side_type           side_in,
   output logic                        out_valid,
   output logic [rei_pkg::QUO_W-1:0]   quo,
   output rei_pkg::side_type           side_out
);
   import rei_pkg::*;

   // one quotient bit per stage, numerator is num shifted up by 2F+2
   logic [QUO_W-1:0] valid_ff;
   side_type         side_ff  [QUO_W];
   logic [M2_W-1:0]  rem_ff   [QUO_W];
   logic [M2_W-1:0]  den_ff   [QUO_W];
   logic [QUO_W-1:0] quo_ff   [QUO_W];

   logic [M2_W:0]    trial    [QUO_W];
   logic [M2_W-1:0]  den_src  [QUO_W];
   logic [QUO_W-1:0] quo_src  [QUO_W];
   logic             take     [QUO_W];
   logic [M2_W-1:0]  rem_in   [QUO_W];
   logic [QUO_W-1:0] quo_in   [QUO_W];

   always_comb begin
      trial[0]   = (M2_W + 1)'(num);
      den_src[0] = den;
      quo_src[0] = '0;
      for (int k = 1; k < QUO_W; k++) begin
         trial[k]   = {rem_ff[k-1], 1'b0};
         den_src[k] = den_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
      for (int k = 0; k < QUO_W; k++) begin
         take[k]   = trial[k] >= {1'b0, den_src[k]};
         rem_in[k] = take[k] ? M2_W'(trial[k] - {1'b0, den_src[k]}) : M2_W'(trial[k]);
         quo_in[k] = {quo_src[k][QUO_W-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QUO_W-2:0], in_valid};
      end
      side_ff[0] <= side_in;
      for (int k = 1; k < QUO_W; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      for (int k = 0; k < QUO_W; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_src[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

[src/rei_sqrt.sv]
`timescale 1ns / 1ps
module rei_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [rei_pkg::QUO_W-1:0]    rad,
   input  rei_pkg::side_type            side_in,
   output logic                         out_valid,
   output logic [rei_pkg::ROOT_W-1:0]   root,
   output rei_pkg::side_type            side_out
);
   import rei_pkg::*;

   // digit-by-digit integer root, one root bit per stage
   logic [ROOT_W-1:0]     valid_ff;
   side_type              side_ff  [ROOT_W];
   logic [SQRT_REM_W-1:0] rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]     root_ff  [ROOT_W];
   logic [RAD_W-1:0]      rad_ff   [ROOT_W];

   logic [SQRT_REM_W-1:0] rem_src  [ROOT_W];
   logic [ROOT_W-1:0]     root_src [ROOT_W];
   logic [RAD_W-1:0]      rad_src  [ROOT_W];
   logic [SQRT_REM_W+1:0] work     [ROOT_W];
   logic [SQRT_REM_W+1:0] trial    [ROOT_W];
   logic                  take     [ROOT_W];
   logic [SQRT_REM_W-1:0] rem_in   [ROOT_W];
   logic [ROOT_W-1:0]     root_in  [ROOT_W];
   logic [RAD_W-1:0]      rad_in   [ROOT_W];

   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      rad_src[0]  = RAD_W'(rad);
      for (int k = 1; k < ROOT_W; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         rad_src[k]  = rad_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         work[k]    = {rem_src[k], rad_src[k][RAD_W-1 -: 2]};
         trial[k]   = (SQRT_REM_W + 2)'({root_src[k], 2'b01});
         take[k]    = work[k] >= trial[k];
         rem_in[k]  = take[k] ? SQRT_REM_W'(work[k] - trial[k]) : SQRT_REM_W'(work[k]);
         root_in[k] = {root_src[k][ROOT_W-2:0], take[k]};
         rad_in[k]  = {rad_src[k][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[ROOT_W-2:0], in_valid};
      end
      side_ff[0] <= side_in;
      for (int k = 1; k < ROOT_W; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         rad_ff[k]  <= rad_in[k];
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign side_out  = side_ff[ROOT_W-1];

endmodule

[src/rei_checker.sv]
`timescale 1ns / 1ps
module rei_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic signed [rei_pkg::IO_W-1:0] req_cos_in,
   input logic signed [rei_pkg::IO_W-1:0] req_sin_in,
   input logic                            rsp_valid,
   input logic signed [rei_pkg::IO_W-1:0] rsp_cos_out,
   input logic signed [rei_pkg::IO_W-1:0] rsp_sin_out,
   input logic                            rsp_zero_magnitude
);
   import rei_pkg::*;

   // every transfer in comes out after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_valid)
      else $error("accepted item produced no result");

   // no result without a matching transfer in
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without an accepted item");

   a_zero_in_zero_out: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cos_in == 0 && req_sin_in == 0 |-> ##LATENCY rsp_zero_magnitude)
      else $error("zero pair not flagged");

   a_zero_flag_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_magnitude |-> rsp_cos_out == 0 && rsp_sin_out == 0)
      else $error("zero flag with non-zero outputs");

   // a unit vector always has one part of at least 1/sqrt(2)
   a_unit_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_magnitude |-> rsp_cos_out != 0 || rsp_sin_out != 0)
      else $error("non-zero pair normalised to zero");

endmodule

bind rotation_euler_integrate_unit rei_checker u_rei_checker (.*);

[tb/sv/rotation_step_checker.sv]
`timescale 1ns / 1ps
module rotation_step_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic signed [rei_pkg::IO_W-1:0] req_cos_in,
   input  logic signed [rei_pkg::IO_W-1:0] req_sin_in,
   input  logic signed [rei_pkg::IO_W-1:0] req_delta_angle,
   input  logic                            rsp_valid,
   input  logic signed [rei_pkg::IO_W-1:0] rsp_cos_out,
   input  logic signed [rei_pkg::IO_W-1:0] rsp_sin_out,
   input  logic                            rsp_zero_magnitude,
   output int                              failures,
   output int                              outstanding
);
   import rei_pkg::*;

   localparam longint OUT_MAX = (longint'(1) <<< (IO_W - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   typedef struct packed {
      logic signed [IO_W-1:0] cos_out;
      logic signed [IO_W-1:0] sin_out;
      logic                   zero_magnitude;
   } rotation_type;

   rotation_type rotations_due[$];

   // largest q <= 1.0 with |v| * 2^F / sqrt(m2) >= q - 1/2, i.e. round half away
   function automatic logic signed [IO_W-1:0] scale_to_unit(input longint v,
                                                            input longint unsigned m2);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] odd;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned cand;
      longint r;
      int b;
      mag = (v < 0) ? -v : v;
      q = 0;
      rhs = (128'(mag) * 128'(mag)) << (2 * FRAC_BITS + 2);
      for (b = FRAC_BITS; b >= 0; b--) begin
         cand = q | (64'd1 << b);
         odd = 128'(2 * cand - 1);
         lhs = odd * odd * 128'(m2);
         if (cand <= (64'd1 << FRAC_BITS) && lhs <= rhs)
            q = cand;
      end
      r = (v < 0) ? -longint'(q) : longint'(q);
      if (r > OUT_MAX)
         r = OUT_MAX;
      if (r < OUT_MIN)
         r = OUT_MIN;
      return IO_W'(r);
   endfunction

   function automatic rotation_type step_and_renormalize(input logic signed [IO_W-1:0] c_in,
                                                         input logic signed [IO_W-1:0] s_in,
                                                         input logic signed [IO_W-1:0] d_in);
      rotation_type res;
      longint c;
      longint s;
      longint d;
      longint c2;
      longint s2;
      longint unsigned m2;
      c = c_in;
      s = s_in;
      d = d_in;
      // products rounded to nearest, ties upward
      c2 = c - ((d * s + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      s2 = s + ((d * c + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      m2 = c2 * c2 + s2 * s2;
      if (m2 == 0) begin
         res.cos_out = '0;
         res.sin_out = '0;
         res.zero_magnitude = 1'b1;
      end else begin
         res.cos_out = scale_to_unit(c2, m2);
         res.sin_out = scale_to_unit(s2, m2);
         res.zero_magnitude = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rotation_type want;
      int bad;
      bad = 0;
      if (reset) begin
         rotations_due.delete();
         failures <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid) begin
            if (rotations_due.size() == 0) begin
               $display("%0t unexpected result: cos %0d sin %0d zero %0b", $time,
                        rsp_cos_out, rsp_sin_out, rsp_zero_magnitude);
               bad++;
            end else begin
               want = rotations_due.pop_front();
               if (rsp_cos_out !== want.cos_out) begin
                  $display("%0t cos_out mismatch: expected %0d, actual %0d", $time,
                           want.cos_out, rsp_cos_out);
                  bad++;
               end
               if (rsp_sin_out !== want.sin_out) begin
                  $display("%0t sin_out mismatch: expected %0d, actual %0d", $time,
                           want.sin_out, rsp_sin_out);
                  bad++;
               end
               if (rsp_zero_magnitude !== want.zero_magnitude) begin
                  $display("%0t zero_magnitude mismatch: expected %0b, actual %0b", $time,
                           want.zero_magnitude, rsp_zero_magnitude);
                  bad++;
               end
            end
         end
         if (start && !busy)
            rotations_due.push_back(step_and_renormalize(req_cos_in, req_sin_in,
                                                         req_delta_angle));
         failures <= failures + bad;
         outstanding <= rotations_due.size();
      end
   end

endmodule

[tb/sv/rotation_euler_integrate_unit_test.sv]
`timescale 1ns / 1ps
module rotation_euler_integrate_unit_test;
   import rei_pkg::*;

   localparam int RANDOM_ROTATIONS = 1230;
   localparam int CYCLE_LIMIT = 400000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic signed [IO_W-1:0] req_cos_in;
   logic signed [IO_W-1:0] req_sin_in;
   logic signed [IO_W-1:0] req_delta_angle;
   logic                   rsp_valid;
   logic signed [IO_W-1:0] rsp_cos_out;
   logic signed [IO_W-1:0] rsp_sin_out;
   logic                   rsp_zero_magnitude;
   int                     failures;
   int                     outstanding;
   int                     cycle_count = 0;
   int                     burst_left = 0;

   rotation_euler_integrate_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cos_in         (req_cos_in),
      .req_sin_in         (req_sin_in),
      .req_delta_angle    (req_delta_angle),
      .rsp_valid          (rsp_valid),
      .rsp_cos_out        (rsp_cos_out),
      .rsp_sin_out        (rsp_sin_out),
      .rsp_zero_magnitude (rsp_zero_magnitude)
   );

   rotation_step_checker rotation_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cos_in         (req_cos_in),
      .req_sin_in         (req_sin_in),
      .req_delta_angle    (req_delta_angle),
      .rsp_valid          (rsp_valid),
      .rsp_cos_out        (rsp_cos_out),
      .rsp_sin_out        (rsp_sin_out),
      .rsp_zero_magnitude (rsp_zero_magnitude),
      .failures           (failures),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // mostly back to back, some short gaps, a few long ones, and bursts with none
   task automatic idle_after_transfer();
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (pick < 55)
         gap = 0;
      else if (pick < 88)
         gap = $urandom_range(1, 3);
      else if (pick < 97)
         gap = $urandom_range(4, 12);
      else
         gap = $urandom_range(20, 70);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_rotation(input logic signed [IO_W-1:0] c,
                                input logic signed [IO_W-1:0] s,
                                input logic signed [IO_W-1:0] d);
      @(negedge clock);
      start <= 1'b1;
      req_cos_in <= c;
      req_sin_in <= s;
      req_delta_angle <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      idle_after_transfer();
   endtask

   task automatic drain_rotations();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic signed [IO_W-1:0] corner_value();
      case ($urandom_range(0, 6))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return -16'sd1;
         3: return 16'sd1;
         4: return 16'sd16384;
         5: return -16'sd16384;
         default: return 16'sd0;
      endcase
   endfunction

   task automatic send_random_rotation();
      logic signed [IO_W-1:0] c;
      logic signed [IO_W-1:0] s;
      logic signed [IO_W-1:0] d;
      int kind;
      kind = $urandom_range(0, 9);
      c = IO_W'($urandom());
      s = IO_W'($urandom());
      d = IO_W'($urandom());
      if (kind < 4) begin
         // parts within plus or minus 1.0, with a small step
         c = IO_W'(int'($urandom_range(0, 32768)) - 16384);
         s = IO_W'(int'($urandom_range(0, 32768)) - 16384);
         d = IO_W'(int'($urandom_range(0, 1024)) - 512);
      end else if (kind == 7) begin
         c = IO_W'(int'($urandom_range(0, 8)) - 4);
         s = IO_W'(int'($urandom_range(0, 8)) - 4);
      end else if (kind == 8) begin
         c = '0;
         s = '0;
      end else if (kind == 9) begin
         c = corner_value();
         s = corner_value();
         d = corner_value();
      end
      send_rotation(c, s, d);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_cos_in = '0;
      req_sin_in = '0;
      req_delta_angle = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_rotation(0, 0, 0);
      send_rotation(0, 0, 32767);
      send_rotation(0, 0, -32768);
      send_rotation(16384, 0, 0);
      send_rotation(0, 16384, 0);
      send_rotation(-16384, 0, 0);
      send_rotation(0, -16384, 0);
      send_rotation(16384, 0, 100);
      send_rotation(11585, 11585, -200);
      send_rotation(32767, 32767, 32767);
      send_rotation(-32768, -32768, -32768);
      send_rotation(32767, -32768, 32767);
      send_rotation(-32768, 32767, -32768);
      send_rotation(1, 0, 0);
      send_rotation(0, -1, 0);
      send_rotation(1, 1, 16384);
      // step products land exactly on a half
      send_rotation(1, -1, 8192);
      send_rotation(-1, 1, 8192);
      send_rotation(3, 4, 0);
      send_rotation(32767, 0, -32768);
      send_rotation(0, 32767, 32767);
      send_rotation(-1, -1, -1);
      send_rotation(16384, 16384, 16384);

      for (int i = 0; i < RANDOM_ROTATIONS; i++) begin
         if (i == RANDOM_ROTATIONS / 2)
            drain_rotations();
         if ($urandom_range(0, 199) == 0)
            burst_left = $urandom_range(20, 80);
         send_random_rotation();
      end

      drain_rotations();
      repeat (LATENCY + 20) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
